// ===== design/soat_pkg.sv =====
// Shared types, codes and constants for the shape overlap test pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package soat_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int EPS_BITS = 8;
   localparam logic [EPS_BITS-1:0] EPS_RESET = 8'd1;
   localparam int EPS_SQ_SHIFT = 4;

   typedef enum logic [1:0] {
      KIND_POINT   = 2'd0,
      KIND_CIRCLE  = 2'd1,
      KIND_BOX     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_MISS       = 2'd0,
      VERDICT_HIT        = 2'd1,
      VERDICT_UNRESOLVED = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      TEST_POINT_POINT,
      TEST_CIRCLE_POINT,
      TEST_CIRCLE_CIRCLE,
      TEST_BOX_POINT,
      TEST_BOX_CIRCLE,
      TEST_BOX_BOX,
      TEST_UNKNOWN
   } test_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // lo holds the lower kind, hi the higher
   function automatic test_type pick_test(kind_type lo, kind_type hi);
      test_type t;
      t = TEST_UNKNOWN;
      if (lo != KIND_UNKNOWN && hi != KIND_UNKNOWN) begin
         case ({lo, hi})
            {KIND_POINT, KIND_POINT}:   t = TEST_POINT_POINT;
            {KIND_POINT, KIND_CIRCLE}:  t = TEST_CIRCLE_POINT;
            {KIND_POINT, KIND_BOX}:     t = TEST_BOX_POINT;
            {KIND_CIRCLE, KIND_CIRCLE}: t = TEST_CIRCLE_CIRCLE;
            {KIND_CIRCLE, KIND_BOX}:    t = TEST_BOX_CIRCLE;
            {KIND_BOX, KIND_BOX}:       t = TEST_BOX_BOX;
            default:                    t = TEST_UNKNOWN;
         endcase
      end
      return t;
   endfunction

endpackage

// ===== design/soat_order.sv =====
// Stage 1: classify the pair, order shapes by kind, form box corners and reach.
// Depends on soat_pkg.
`timescale 1ns / 1ps

module soat_order
   import soat_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  stage_en_type                 en,
   input  logic [1:0]                   kind_a,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic [COORD_BITS-2:0]        a_size_x,
   input  logic [COORD_BITS-2:0]        a_size_y,
   input  logic [1:0]                   kind_b,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic [COORD_BITS-2:0]        b_size_x,
   input  logic [COORD_BITS-2:0]        b_size_y,
   output test_type                     test,
   output logic signed [COORD_BITS-1:0] p_x,
   output logic signed [COORD_BITS-1:0] p_y,
   output logic signed [COORD_BITS:0]   p_max_x,
   output logic signed [COORD_BITS:0]   p_max_y,
   output logic signed [COORD_BITS-1:0] q_x,
   output logic signed [COORD_BITS-1:0] q_y,
   output logic signed [COORD_BITS:0]   q_max_x,
   output logic signed [COORD_BITS:0]   q_max_y,
   output logic [COORD_BITS-1:0]        reach
);

   localparam int CB = COORD_BITS;
   localparam int WB = COORD_BITS + 1;

   kind_type kind_a_k, kind_b_k;
   logic     swap;

   logic signed [CB-1:0] px_sel, py_sel, qx_sel, qy_sel;
   logic [CB-2:0]        psx_sel, psy_sel, qsx_sel, qsy_sel;

   test_type             test_in, test_ff;
   logic signed [CB-1:0] p_x_ff, p_y_ff, q_x_ff, q_y_ff;
   logic signed [WB-1:0] p_max_x_in, p_max_y_in, q_max_x_in, q_max_y_in;
   logic signed [WB-1:0] p_max_x_ff, p_max_y_ff, q_max_x_ff, q_max_y_ff;
   logic [CB-1:0]        reach_in, reach_ff;

   assign kind_a_k = kind_type'(kind_a);
   assign kind_b_k = kind_type'(kind_b);
   assign swap     = kind_a > kind_b;

   always_comb begin
      if (swap) begin
         px_sel  = b_x;      py_sel  = b_y;
         psx_sel = b_size_x; psy_sel = b_size_y;
         qx_sel  = a_x;      qy_sel  = a_y;
         qsx_sel = a_size_x; qsy_sel = a_size_y;
         test_in = pick_test(kind_b_k, kind_a_k);
      end else begin
         px_sel  = a_x;      py_sel  = a_y;
         psx_sel = a_size_x; psy_sel = a_size_y;
         qx_sel  = b_x;      qy_sel  = b_y;
         qsx_sel = b_size_x; qsy_sel = b_size_y;
         test_in = pick_test(kind_a_k, kind_b_k);
      end
   end

   assign p_max_x_in = WB'(px_sel) + $signed({2'b00, psx_sel});
   assign p_max_y_in = WB'(py_sel) + $signed({2'b00, psy_sel});
   assign q_max_x_in = WB'(qx_sel) + $signed({2'b00, qsx_sel});
   assign q_max_y_in = WB'(qy_sel) + $signed({2'b00, qsy_sel});

   always_comb begin
      case (test_in)
         TEST_CIRCLE_POINT:  reach_in = {1'b0, qsx_sel};
         TEST_CIRCLE_CIRCLE: reach_in = {1'b0, psx_sel} + {1'b0, qsx_sel};
         TEST_BOX_CIRCLE:    reach_in = {1'b0, psx_sel};
         default:            reach_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         test_ff    <= test_in;
         p_x_ff     <= px_sel;
         p_y_ff     <= py_sel;
         q_x_ff     <= qx_sel;
         q_y_ff     <= qy_sel;
         p_max_x_ff <= p_max_x_in;
         p_max_y_ff <= p_max_y_in;
         q_max_x_ff <= q_max_x_in;
         q_max_y_ff <= q_max_y_in;
         reach_ff   <= reach_in;
      end
   end

   assign test    = test_ff;
   assign p_x     = p_x_ff;
   assign p_y     = p_y_ff;
   assign q_x     = q_x_ff;
   assign q_y     = q_y_ff;
   assign p_max_x = p_max_x_ff;
   assign p_max_y = p_max_y_ff;
   assign q_max_x = q_max_x_ff;
   assign q_max_y = q_max_y_ff;
   assign reach   = reach_ff;

endmodule

// ===== design/soat_geom.sv =====
// Stages 2 and 3: box edge tests, centre clamp, then absolute distances.
// Depends on soat_pkg; fed by soat_order.
`timescale 1ns / 1ps

module soat_geom
   import soat_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  stage_en_type                 en,
   input  logic [EPS_BITS-1:0]          epsilon,
   input  test_type                     test_i,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   input  logic signed [COORD_BITS:0]   p_max_x,
   input  logic signed [COORD_BITS:0]   p_max_y,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   input  logic signed [COORD_BITS:0]   q_max_x,
   input  logic signed [COORD_BITS:0]   q_max_y,
   input  logic [COORD_BITS-1:0]        reach_i,
   output test_type                     test_o,
   output logic                         box_hit,
   output logic [COORD_BITS-1:0]        dist_x,
   output logic [COORD_BITS-1:0]        dist_y,
   output logic [COORD_BITS-1:0]        reach_o
);

   localparam int CB = COORD_BITS;
   localparam int WB = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 2;

   logic signed [EW-1:0] eps_e;
   logic signed [EW-1:0] px_e, py_e, qx_e, qy_e;
   logic signed [EW-1:0] pmx_e, pmy_e, qmx_e, qmy_e;
   logic                 bp_miss, bb_miss, box_hit_in;
   logic signed [WB-1:0] near_x, near_y, from_x_in, from_y_in;

   test_type             test2_ff, test3_ff;
   logic                 box_hit2_ff, box_hit3_ff;
   logic signed [WB-1:0] from_x_ff, from_y_ff;
   logic signed [CB-1:0] to_x_ff, to_y_ff;
   logic [CB-1:0]        reach2_ff, reach3_ff;

   logic signed [EW-1:0] diff_x, diff_y;
   logic signed [EW-1:0] abs_x, abs_y;
   logic [CB-1:0]        dist_x_ff, dist_y_ff;

   assign eps_e = $signed({{(EW-EPS_BITS){1'b0}}, epsilon});
   assign px_e  = EW'(p_x);
   assign py_e  = EW'(p_y);
   assign qx_e  = EW'(q_x);
   assign qy_e  = EW'(q_y);
   assign pmx_e = EW'(p_max_x);
   assign pmy_e = EW'(p_max_y);
   assign qmx_e = EW'(q_max_x);
   assign qmy_e = EW'(q_max_y);

   // point p against box q
   assign bp_miss = (px_e + eps_e >= qmx_e) || (py_e + eps_e >= qmy_e) ||
                    (px_e - eps_e <= qx_e)  || (py_e - eps_e <= qy_e);
   // box p against box q
   assign bb_miss = (qx_e + eps_e >= pmx_e) || (qy_e + eps_e >= pmy_e) ||
                    (qmx_e - eps_e <= px_e) || (qmy_e - eps_e <= py_e);

   always_comb begin
      case (test_i)
         TEST_BOX_POINT: box_hit_in = !bp_miss;
         TEST_BOX_BOX:   box_hit_in = !bb_miss;
         default:        box_hit_in = 1'b0;
      endcase
   end

   // clamp circle centre p into box q
   always_comb begin
      if (p_x < q_x) begin
         near_x = WB'(q_x);
      end else if (WB'(p_x) > q_max_x) begin
         near_x = q_max_x;
      end else begin
         near_x = WB'(p_x);
      end
      if (p_y < q_y) begin
         near_y = WB'(q_y);
      end else if (WB'(p_y) > q_max_y) begin
         near_y = q_max_y;
      end else begin
         near_y = WB'(p_y);
      end
   end

   always_comb begin
      case (test_i)
         TEST_BOX_CIRCLE: begin
            from_x_in = near_x;
            from_y_in = near_y;
         end
         default: begin
            from_x_in = WB'(q_x);
            from_y_in = WB'(q_y);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         test2_ff    <= test_i;
         box_hit2_ff <= box_hit_in;
         from_x_ff   <= from_x_in;
         from_y_ff   <= from_y_in;
         to_x_ff     <= p_x;
         to_y_ff     <= p_y;
         reach2_ff   <= reach_i;
      end
   end

   assign diff_x = EW'(from_x_ff) - EW'(to_x_ff);
   assign diff_y = EW'(from_y_ff) - EW'(to_y_ff);
   assign abs_x  = diff_x[EW-1] ? -diff_x : diff_x;
   assign abs_y  = diff_y[EW-1] ? -diff_y : diff_y;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         test3_ff    <= test2_ff;
         box_hit3_ff <= box_hit2_ff;
         dist_x_ff   <= abs_x[CB-1:0];
         dist_y_ff   <= abs_y[CB-1:0];
         reach3_ff   <= reach2_ff;
      end
   end

   assign test_o  = test3_ff;
   assign box_hit = box_hit3_ff;
   assign dist_x  = dist_x_ff;
   assign dist_y  = dist_y_ff;
   assign reach_o = reach3_ff;

endmodule

// ===== design/soat_dist.sv =====
// Stages 4 and 5: square distances and reach, compare, register the verdict.
// Depends on soat_pkg; fed by soat_geom.
`timescale 1ns / 1ps

module soat_dist
   import soat_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  stage_en_type          en,
   input  logic [EPS_BITS-1:0]   epsilon,
   input  test_type              test_i,
   input  logic                  box_hit,
   input  logic [COORD_BITS-1:0] dist_x,
   input  logic [COORD_BITS-1:0] dist_y,
   input  logic [COORD_BITS-1:0] reach,
   output logic [1:0]            verdict
);

   localparam int CB = COORD_BITS;
   localparam int QB = 2 * COORD_BITS;
   localparam int SW = 2 * COORD_BITS + 1;

   logic [QB-1:0] sq_x_in, sq_y_in, sq_r_in;
   logic [QB-1:0] sq_x_ff, sq_y_ff, sq_r_ff;
   test_type      test4_ff;
   logic          box_hit4_ff;
   logic [SW-1:0] lhs, rhs;
   logic          near_hit;
   verdict_type   verdict_in, verdict_ff;

   assign sq_x_in = {{CB{1'b0}}, dist_x} * {{CB{1'b0}}, dist_x};
   assign sq_y_in = {{CB{1'b0}}, dist_y} * {{CB{1'b0}}, dist_y};
   assign sq_r_in = {{CB{1'b0}}, reach} * {{CB{1'b0}}, reach};

   always_ff @(posedge clock) begin
      if (en.s4) begin
         test4_ff    <= test_i;
         box_hit4_ff <= box_hit;
         sq_x_ff     <= sq_x_in;
         sq_y_ff     <= sq_y_in;
         sq_r_ff     <= sq_r_in;
      end
   end

   assign lhs = SW'(sq_x_ff) + SW'(sq_y_ff);
   assign rhs = SW'(sq_r_ff) + SW'({epsilon, {EPS_SQ_SHIFT{1'b0}}});
   assign near_hit = lhs <= rhs;

   always_comb begin
      case (test4_ff)
         TEST_UNKNOWN:       verdict_in = VERDICT_UNRESOLVED;
         TEST_CIRCLE_POINT,
         TEST_CIRCLE_CIRCLE,
         TEST_BOX_CIRCLE:    verdict_in = near_hit ? VERDICT_HIT : VERDICT_MISS;
         TEST_BOX_POINT,
         TEST_BOX_BOX:       verdict_in = box_hit4_ff ? VERDICT_HIT : VERDICT_MISS;
         default:            verdict_in = VERDICT_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         verdict_ff <= verdict_in;
      end
   end

   assign verdict = verdict_ff;

endmodule

// ===== design/shape_overlap_test.sv =====
// Top level of the shape overlap test: stage control, tolerance register.
// Depends on soat_pkg, soat_order, soat_geom and soat_dist.
`timescale 1ns / 1ps

// Usage:
//   req_ channel: one item per accepted cycle, two shapes (point, circle or
//   box) with kinds, positions and sizes. Accepted when req_valid is high and
//   req_stall is low.
//   rsp_ channel: one verdict per item, in order: miss, hit, or unresolved
//   when either kind is unknown. Taken when rsp_valid is high and rsp_stall
//   is low.
//   csr_ port: csr_wr_en writes csr_wr_data into the tolerance; write only
//   while no item is in flight.
// Pipeline: an accepted item reaches rsp_valid through the order, clamp and edge
//   tests, distance, squares and compare stages.
// Throughput: one item per cycle while no stall holds the pipeline, set by the
//   five-stage pipeline with one multiplier per square in stage four.
// Reset: empties the pipeline and sets the tolerance to one.
// Stall: a held result keeps its stage; earlier stages keep moving into
//   empty slots, and req_stall rises only once every stage holds an item.
module shape_overlap_test
   import soat_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind_a,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic [COORD_BITS-2:0]        req_a_size_x,
   input  logic [COORD_BITS-2:0]        req_a_size_y,
   input  logic [1:0]                   req_kind_b,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic [COORD_BITS-2:0]        req_b_size_x,
   input  logic [COORD_BITS-2:0]        req_b_size_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_verdict,
   input  logic                         csr_wr_en,
   input  logic [EPS_BITS-1:0]          csr_wr_data
);

   localparam int CB = COORD_BITS;

   stage_en_type        en;
   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [EPS_BITS-1:0] epsilon_ff;

   test_type             test1, test3;
   logic signed [CB-1:0] p_x, p_y, q_x, q_y;
   logic signed [CB:0]   p_max_x, p_max_y, q_max_x, q_max_y;
   logic [CB-1:0]        reach1, reach3, dist_x, dist_y;
   logic                 box_hit;

   assign en.s5 = !v5_ff || !rsp_stall;
   assign en.s4 = !v4_ff || en.s5;
   assign en.s3 = !v3_ff || en.s4;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req_stall = !en.s1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
         if (en.s5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         epsilon_ff <= csr_wr_data;
      end
   end

   soat_order #(.COORD_BITS(COORD_BITS)) u_order (
      .clock    (clock),
      .en       (en),
      .kind_a   (req_kind_a),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_size_x (req_a_size_x),
      .a_size_y (req_a_size_y),
      .kind_b   (req_kind_b),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_size_x (req_b_size_x),
      .b_size_y (req_b_size_y),
      .test     (test1),
      .p_x      (p_x),
      .p_y      (p_y),
      .p_max_x  (p_max_x),
      .p_max_y  (p_max_y),
      .q_x      (q_x),
      .q_y      (q_y),
      .q_max_x  (q_max_x),
      .q_max_y  (q_max_y),
      .reach    (reach1)
   );

   soat_geom #(.COORD_BITS(COORD_BITS)) u_geom (
      .clock   (clock),
      .en      (en),
      .epsilon (epsilon_ff),
      .test_i  (test1),
      .p_x     (p_x),
      .p_y     (p_y),
      .p_max_x (p_max_x),
      .p_max_y (p_max_y),
      .q_x     (q_x),
      .q_y     (q_y),
      .q_max_x (q_max_x),
      .q_max_y (q_max_y),
      .reach_i (reach1),
      .test_o  (test3),
      .box_hit (box_hit),
      .dist_x  (dist_x),
      .dist_y  (dist_y),
      .reach_o (reach3)
   );

   soat_dist #(.COORD_BITS(COORD_BITS)) u_dist (
      .clock   (clock),
      .en      (en),
      .epsilon (epsilon_ff),
      .test_i  (test3),
      .box_hit (box_hit),
      .dist_x  (dist_x),
      .dist_y  (dist_y),
      .reach   (reach3),
      .verdict (rsp_verdict)
   );

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("input stalled while a stage is empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted item missing from first stage");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v4_ff) |=> !rsp_valid)
      else $error("result repeated after being taken");
`endif

endmodule

// ===== dv/shape_overlap_test_tb.sv =====
// Self-checking testbench for shape_overlap_test: directed and random shape pairs, a
// local verdict predictor, and random sender and receiver stalls. Depends on soat_pkg and shape_overlap_test.
`timescale 1ns / 1ps

module shape_overlap_test_tb;
   import soat_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEFAULT;
   localparam int SIZE_BITS = COORD_BITS - 1;

   typedef struct {
      kind_type                       kind;
      logic signed [COORD_BITS-1:0]   x;
      logic signed [COORD_BITS-1:0]   y;
      logic [SIZE_BITS-1:0]           sx;
      logic [SIZE_BITS-1:0]           sy;
   } shape_desc_type;

   typedef struct {
      shape_desc_type a;
      shape_desc_type b;
   } shape_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_kind_a = '0;
   logic signed [COORD_BITS-1:0] req_a_x = '0;
   logic signed [COORD_BITS-1:0] req_a_y = '0;
   logic [SIZE_BITS-1:0]         req_a_size_x = '0;
   logic [SIZE_BITS-1:0]         req_a_size_y = '0;
   logic [1:0]                   req_kind_b = '0;
   logic signed [COORD_BITS-1:0] req_b_x = '0;
   logic signed [COORD_BITS-1:0] req_b_y = '0;
   logic [SIZE_BITS-1:0]         req_b_size_x = '0;
   logic [SIZE_BITS-1:0]         req_b_size_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_verdict;
   logic                         csr_wr_en = 1'b0;
   logic [EPS_BITS-1:0]          csr_wr_data = '0;

   shape_pair_type    pending_pairs[$];
   verdict_type       expected_verdicts[$];
   shape_pair_type    next_pair;
   shape_desc_type    seen_a;
   shape_desc_type    seen_b;
   verdict_type       want;
   logic [EPS_BITS-1:0] epsilon_now = EPS_RESET;
   logic              req_took = 1'b0;
   bit                calm = 1'b0;
   int                send_gap = 0;
   int                stall_left = 0;
   int                mismatch_count = 0;

   shape_overlap_test #(.COORD_BITS(COORD_BITS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind_a   (req_kind_a),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_size_x (req_a_size_x),
      .req_a_size_y (req_a_size_y),
      .req_kind_b   (req_kind_b),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_size_x (req_b_size_x),
      .req_b_size_y (req_b_size_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_verdict  (rsp_verdict),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic longint sq_dist(longint x0, longint y0, longint x1, longint y1);
      return (x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1);
   endfunction

   function automatic verdict_type judge_pair(shape_desc_type s0, shape_desc_type s1,
                                              logic [EPS_BITS-1:0] eps);
      shape_desc_type lo;
      shape_desc_type hi;
      longint e, slack, lx, ly, lsx, lsy, hx, hy, hsx, hsy, nx, ny, reach;
      bit hit;
      if (s0.kind == KIND_UNKNOWN || s1.kind == KIND_UNKNOWN)
         return VERDICT_UNRESOLVED;
      if (s0.kind <= s1.kind) begin
         lo = s0;
         hi = s1;
      end else begin
         lo = s1;
         hi = s0;
      end
      e = longint'(eps);
      slack = e << EPS_SQ_SHIFT;
      lx = lo.x;
      ly = lo.y;
      lsx = longint'(lo.sx);
      lsy = longint'(lo.sy);
      hx = hi.x;
      hy = hi.y;
      hsx = longint'(hi.sx);
      hsy = longint'(hi.sy);
      hit = 1'b0;
      case ({lo.kind, hi.kind})
         {KIND_POINT, KIND_CIRCLE}: begin
            hit = sq_dist(hx, hy, lx, ly) <= hsx * hsx + slack;
         end
         {KIND_CIRCLE, KIND_CIRCLE}: begin
            reach = lsx + hsx;
            hit = sq_dist(lx, ly, hx, hy) <= reach * reach + slack;
         end
         {KIND_POINT, KIND_BOX}: begin
            hit = !(lx + e >= hx + hsx || ly + e >= hy + hsy || lx - e <= hx || ly - e <= hy);
         end
         {KIND_CIRCLE, KIND_BOX}: begin
            nx = (lx < hx) ? hx : ((lx > hx + hsx) ? hx + hsx : lx);
            ny = (ly < hy) ? hy : ((ly > hy + hsy) ? hy + hsy : ly);
            hit = sq_dist(nx, ny, lx, ly) <= lsx * lsx + slack;
         end
         {KIND_BOX, KIND_BOX}: begin
            hit = !(hx + e >= lx + lsx || hy + e >= ly + lsy ||
                    hx + hsx - e <= lx || hy + hsy - e <= ly);
         end
         default: hit = 1'b0;
      endcase
      return hit ? VERDICT_HIT : VERDICT_MISS;
   endfunction

   function automatic shape_desc_type random_shape(bit wild, int cx, int cy);
      shape_desc_type s;
      int reach;
      int spread;
      if (wild) begin
         s.kind = kind_type'($urandom_range(0, 3));
         s.x = COORD_BITS'($urandom);
         s.y = COORD_BITS'($urandom);
         s.sx = SIZE_BITS'($urandom);
         s.sy = SIZE_BITS'($urandom);
         return s;
      end
      s.kind = ($urandom_range(0, 19) == 0) ? KIND_UNKNOWN : kind_type'($urandom_range(0, 2));
      reach = ($urandom_range(0, 15) == 0) ? 32767 : 1023;
      s.sx = SIZE_BITS'($urandom_range(0, reach));
      s.sy = SIZE_BITS'($urandom_range(0, reach));
      case ($urandom_range(0, 2))
         0: spread = 16;
         1: spread = 512;
         default: spread = 2048;
      endcase
      s.x = COORD_BITS'(cx + int'($urandom_range(0, 2 * spread)) - spread);
      s.y = COORD_BITS'(cy + int'($urandom_range(0, 2 * spread)) - spread);
      return s;
   endfunction

   task automatic queue_pair(kind_type ka, int ax, int ay, int asx, int asy,
                             kind_type kb, int bx, int by, int bsx, int bsy);
      shape_pair_type p;
      p.a = '{ka, COORD_BITS'(ax), COORD_BITS'(ay), SIZE_BITS'(asx), SIZE_BITS'(asy)};
      p.b = '{kb, COORD_BITS'(bx), COORD_BITS'(by), SIZE_BITS'(bsx), SIZE_BITS'(bsy)};
      pending_pairs.push_back(p);
   endtask

   task automatic wait_for_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_pairs.size() != 0 || (req_valid && !req_took) ||
                 expected_verdicts.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [EPS_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sender: hold the item until taken, then advance or idle
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else begin
            next_pair = pending_pairs.pop_front();
            req_kind_a <= next_pair.a.kind;
            req_a_x <= next_pair.a.x;
            req_a_y <= next_pair.a.y;
            req_a_size_x <= next_pair.a.sx;
            req_a_size_y <= next_pair.a.sy;
            req_kind_b <= next_pair.b.kind;
            req_b_x <= next_pair.b.x;
            req_b_y <= next_pair.b.y;
            req_b_size_x <= next_pair.b.sx;
            req_b_size_y <= next_pair.b.sy;
            req_valid <= 1'b1;
         end
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         epsilon_now <= EPS_RESET;
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (csr_wr_en)
            epsilon_now <= csr_wr_data;
         if (req_valid && !req_stall) begin
            seen_a = '{kind_type'(req_kind_a), req_a_x, req_a_y, req_a_size_x, req_a_size_y};
            seen_b = '{kind_type'(req_kind_b), req_b_x, req_b_y, req_b_size_x, req_b_size_y};
            expected_verdicts.push_back(judge_pair(seen_a, seen_b, epsilon_now));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected verdict %0d at %0t", rsp_verdict, $realtime);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_verdict !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("verdict mismatch at %0t: expected %0d, got %0d",
                              $realtime, want, rsp_verdict);
               end
            end
         end
      end
   end

   initial begin
      shape_desc_type sa;
      shape_desc_type sb;
      bit wild;
      logic [EPS_BITS-1:0] eps_pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tolerance at reset value
      queue_pair(KIND_POINT, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0);
      queue_pair(KIND_POINT, -32768, 32767, 32767, 32767, KIND_POINT, 32767, -32768, 0, 0);
      queue_pair(KIND_CIRCLE, 0, 0, 160, 0, KIND_POINT, 160, 0, 0, 0);
      queue_pair(KIND_CIRCLE, 0, 0, 160, 0, KIND_POINT, 161, 0, 0, 0);
      queue_pair(KIND_POINT, 0, 161, 0, 0, KIND_CIRCLE, 0, 0, 160, 0);
      queue_pair(KIND_CIRCLE, 0, 0, 100, 0, KIND_CIRCLE, 200, 0, 100, 0);
      queue_pair(KIND_CIRCLE, 0, 0, 100, 0, KIND_CIRCLE, 201, 0, 100, 0);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_POINT, 160, 160, 0, 0);
      queue_pair(KIND_POINT, 0, 160, 0, 0, KIND_BOX, 0, 0, 320, 320);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_POINT, 319, 319, 0, 0);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_CIRCLE, 400, 160, 64, 0);
      queue_pair(KIND_CIRCLE, 380, 160, 64, 0, KIND_BOX, 0, 0, 320, 320);
      queue_pair(KIND_CIRCLE, 160, 160, 0, 0, KIND_BOX, 0, 0, 320, 320);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_BOX, 160, 160, 320, 320);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_BOX, 320, 0, 320, 320);
      queue_pair(KIND_BOX, 160, -160, 320, 320, KIND_BOX, 0, 0, 320, 320);
      queue_pair(KIND_BOX, 32767, 32767, 32767, 32767, KIND_BOX, 32760, 32760, 32767, 32767);
      queue_pair(KIND_BOX, 32767, 32767, 32767, 32767, KIND_CIRCLE, -32768, -32768, 32767, 0);
      queue_pair(KIND_CIRCLE, -32768, -32768, 32767, 0, KIND_CIRCLE, 32767, 32767, 32767, 0);
      queue_pair(KIND_CIRCLE, -32768, 0, 32767, 0, KIND_POINT, -1, 0, 0, 0);
      queue_pair(KIND_BOX, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0);
      queue_pair(KIND_UNKNOWN, 0, 0, 0, 0, KIND_POINT, 0, 0, 0, 0);
      queue_pair(KIND_BOX, 0, 0, 320, 320, KIND_UNKNOWN, 10, 10, 5, 5);
      queue_pair(KIND_UNKNOWN, -1, -1, 32767, 32767, KIND_UNKNOWN, -1, -1, 32767, 32767);
      wait_for_idle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: eps_pick = '0;
            1: eps_pick = '1;
            2: eps_pick = EPS_BITS'($urandom_range(2, 254));
            default: eps_pick = EPS_BITS'($urandom);
         endcase
         calm = (p == 3);
         write_epsilon(eps_pick);
         repeat ((p == 3) ? 700 : 350) begin
            wild = ($urandom_range(0, 7) == 0);
            sa = random_shape(wild, int'($urandom), int'($urandom));
            sb = random_shape(wild, sa.x, sa.y);
            pending_pairs.push_back('{sa, sb});
         end
         wait_for_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("shape_overlap_test_tb: done, clean");
      end else begin
         $display("shape_overlap_test_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("shape_overlap_test_tb: done, errors");
      $finish;
   end

endmodule
